// ===== sv/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_SAME(label, ante, cons, msg)
`define CHK_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/ddh_pkg.sv =====
// ============================================================================
// ddh_pkg
// Constants shared by the decimal digit histogram.
// ============================================================================
`default_nettype none

package ddh_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int TOTAL_BITS_DEF = 40;

    localparam int NUM_DIGITS = 10;
    localparam logic [3:0] LAST_DIGIT = 4'd9;

    localparam int DIGIT_W = 4;
    localparam int COUNT_W = 4;
    localparam int RT_W    = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    typedef logic [DIGIT_W-1:0] digit_t;

endpackage

`default_nettype wire

// ===== sv/decimal_digit_histogram.sv =====
// ============================================================================
// decimal_digit_histogram
// Counts the decimal digits of each input number and keeps per-digit totals.
// ============================================================================
// Each input beat carries one unsigned number. Its low VALUE_BITS bits are
// converted to BCD one bit per cycle by a shift-and-add-3 register, then the
// BCD digits are scanned one per cycle from the top, leading zeros skipped
// (10 BCD digits at the default width), and then ten result beats go out,
// digit 0 first and digit 9 with last set, one per cycle while out_ready is
// high. The value 0 counts as one zero digit. Running totals saturate at
// all ones and are cleared by reset; a result beat may still wait in the
// output register while the next input beat is taken.
`default_nettype none

module decimal_digit_histogram #(
    parameter int VALUE_BITS = ddh_pkg::VALUE_BITS_DEF,
    parameter int TOTAL_BITS = ddh_pkg::TOTAL_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [VALUE_BITS-1:0]       value,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [ddh_pkg::DIGIT_W-1:0]      digit,
    output logic [ddh_pkg::COUNT_W-1:0]      count_here,
    output logic [ddh_pkg::RT_W-1:0]         running_total,
    output logic                             last
);

    // Decimal digits needed for 2^VALUE_BITS - 1 (1233/4096 ~ log10(2)).
    localparam int NDIG    = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int BCD_W   = 4 * NDIG;
    localparam int CNT_W   = $clog2(NDIG + 1);
    localparam int BIT_CW  = $clog2(VALUE_BITS);
    localparam int SCAN_CW = $clog2(NDIG);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [BIT_CW-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [SCAN_CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                    seen_reg, seen_next;
    ddh_pkg::digit_t         emit_idx_reg, emit_idx_next;
    logic                    out_valid_reg, out_valid_next;

    logic [VALUE_BITS-1:0]   sh_reg, sh_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCD_W-1:0]        bcd_adj;
    logic [CNT_W-1:0]        counts_reg [ddh_pkg::NUM_DIGITS];
    logic [CNT_W-1:0]        counts_next [ddh_pkg::NUM_DIGITS];
    logic [TOTAL_BITS-1:0]   totals_reg [ddh_pkg::NUM_DIGITS];

    logic [ddh_pkg::DIGIT_W-1:0] digit_reg;
    logic [ddh_pkg::COUNT_W-1:0] count_here_reg;
    logic [ddh_pkg::RT_W-1:0]    running_total_reg;
    logic                        last_reg;

    logic [3:0]              top_digit;
    logic                    load;
    logic [TOTAL_BITS:0]     sum;
    logic [TOTAL_BITS-1:0]   new_total;
    logic [7:0]              cnt_wide;
    logic [63:0]             total_wide;

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign digit         = digit_reg;
    assign count_here    = count_here_reg;
    assign running_total = running_total_reg;
    assign last          = last_reg;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign load      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Shift-and-add-3: every BCD digit of five or more is corrected before the shift.
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        sum        = {1'b0, totals_reg[emit_idx_reg]}
                     + (TOTAL_BITS + 1)'(counts_reg[emit_idx_reg]);
        new_total  = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
        cnt_wide   = 8'(counts_reg[emit_idx_reg]);
        total_wide = 64'(new_total);
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        seen_next      = seen_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sh_next        = sh_reg;
        bcd_next       = bcd_reg;
        counts_next    = counts_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sh_next      = value;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CW'(VALUE_BITS - 1);
                    for (int d = 0; d < ddh_pkg::NUM_DIGITS; d++)
                    begin
                        counts_next[d] = '0;
                    end
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], sh_reg[VALUE_BITS-1]};
                sh_next  = sh_reg << 1;
                if (bit_cnt_reg == '0)
                begin
                    scan_cnt_next = SCAN_CW'(NDIG - 1);
                    seen_next     = 1'b0;
                    state_next    = ST_SCAN;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_SCAN:
            begin
                // Leading zeros are skipped, but the units digit always counts.
                if ((seen_reg || top_digit != 4'd0 || scan_cnt_reg == '0)
                    && top_digit <= ddh_pkg::LAST_DIGIT)
                begin
                    counts_next[top_digit] = counts_reg[top_digit] + 1'b1;
                end
                seen_next = seen_reg || (top_digit != 4'd0);
                bcd_next  = bcd_reg << 4;
                if (scan_cnt_reg == '0)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    if (emit_idx_reg == ddh_pkg::LAST_DIGIT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            scan_cnt_reg  <= '0;
            seen_reg      <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < ddh_pkg::NUM_DIGITS; d++)
            begin
                totals_reg[d] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            seen_reg      <= seen_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                totals_reg[emit_idx_reg] <= new_total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg     <= sh_next;
        bcd_reg    <= bcd_next;
        counts_reg <= counts_next;
        if (load)
        begin
            digit_reg         <= emit_idx_reg;
            count_here_reg    <= (cnt_wide > 8'(ddh_pkg::COUNT_MAX))
                                 ? ddh_pkg::COUNT_MAX : cnt_wide[ddh_pkg::COUNT_W-1:0];
            running_total_reg <= total_wide[ddh_pkg::RT_W-1:0];
            last_reg          <= (emit_idx_reg == ddh_pkg::LAST_DIGIT);
        end
    end

`include "assert_macros.svh"

    `CHK_SAME(a_last_on_nine, out_valid && last, digit == ddh_pkg::LAST_DIGIT, "last set on a digit other than nine")
    `CHK_NEXT(a_accept_starts_conv, in_valid && in_ready, state_reg == ST_CONV, "accepted beat did not start conversion")
    `CHK_NEXT(a_nine_ends_run, load && emit_idx_reg == ddh_pkg::LAST_DIGIT, state_reg == ST_IDLE && out_valid && last, "run did not end after digit nine")
    `CHK_SAME(a_no_load_outside_emit, state_reg != ST_EMIT, !load, "result loaded outside emission")

endmodule

`default_nettype wire
